/* rtl/edt_pkg.sv */
// ----------------------------------------------------------------------------
// edt_pkg
// Shared constants for the Euclidean distance table: field widths, the
// fixed-point format of the distance and the item kind codes.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int IDX_W      = 6;
  localparam int COORD_IN_W = 16;
  localparam int DIST_W     = 25;
  localparam int FRAC_BITS  = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

/* rtl/edt_ram.sv */
// ----------------------------------------------------------------------------
// edt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module edt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/edt_sqrt.sv */
// ----------------------------------------------------------------------------
// edt_sqrt
// Iterative fixed-point square root: floor(2^FRAC_BITS * sqrt(radicand)),
// one result bit per cycle, saturated to the distance width.
// ----------------------------------------------------------------------------
module edt_sqrt #(
  parameter int IN_W = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [IN_W-1:0]            radicand,
  output logic                       done,
  output logic [edt_pkg::DIST_W-1:0] root_out
);

  localparam int STEPS  = (IN_W + 1) / 2 + edt_pkg::FRAC_BITS;
  localparam int ROOT_W = STEPS;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SH_W   = 2 * STEPS;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int EXT_W  = (ROOT_W > edt_pkg::DIST_W) ? ROOT_W : edt_pkg::DIST_W;

  logic              active;
  logic [CNT_W-1:0]  cnt;
  logic [SH_W-1:0]   sh;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  rem_sub;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;
  logic [EXT_W-1:0]  root_ext;

  always_comb begin
    rem_sh    = {rem, sh[SH_W-1 -: 2]};
    trial     = (REM_W + 2)'({root, 2'b01});
    rem_sub   = rem_sh - trial;
    ge        = (rem_sh >= trial);
    rem_next  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_next = {root[ROOT_W-2:0], ge};
    root_ext  = EXT_W'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == CNT_W'(1));
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(STEPS);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  // The radicand is scaled by 2^(2*FRAC_BITS) so that the root carries the
  // fraction bits.
  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= SH_W'(radicand) << (2 * edt_pkg::FRAC_BITS);
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      sh   <= sh << 2;
      rem  <= rem_next;
      root <= root_next;
    end
  end

  assign root_out = (root_ext > EXT_W'(edt_pkg::DIST_MAX)) ? edt_pkg::DIST_MAX
                                                           : edt_pkg::DIST_W'(root);

endmodule

/* rtl/euclidean_distance_table.sv */
// Query: distance is strobed by done after two reads of the coordinate RAM, the
// difference, square and sum stages and the iterative square-root unit, which
// yields one root bit per cycle. busy drops with the strobe, and no new item
// is taken while a query is in progress.
// An in-range load is written in its accepting cycle and a new item may follow at once.
// rst is synchronous; the coordinate table is undefined until loaded; no result stalls.
// ----------------------------------------------------------------------------
// euclidean_distance_table
// Table of city coordinates answering Euclidean distance queries between two
// stored cities, as unsigned fixed point with eight fraction bits (zero for an out-of-range index).
// ----------------------------------------------------------------------------
module euclidean_distance_table #(
  parameter int MAX_CITIES = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind,
  input  logic [edt_pkg::IDX_W-1:0]      index_a,
  input  logic [edt_pkg::IDX_W-1:0]      index_b,
  input  logic signed [edt_pkg::COORD_IN_W-1:0] coord_x,
  input  logic signed [edt_pkg::COORD_IN_W-1:0] coord_y,
  output logic                           done,
  output logic [edt_pkg::DIST_W-1:0]     distance
);

  localparam int AW    = $clog2(MAX_CITIES);
  localparam int C     = COORD_BITS;
  localparam int SQ_W  = 2 * C;
  localparam int SUM_W = 2 * C + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FETCH_B = 3'd1;
  localparam logic [2:0] S_DIFF    = 3'd2;
  localparam logic [2:0] S_SQUARE  = 3'd3;
  localparam logic [2:0] S_SUM     = 3'd4;
  localparam logic [2:0] S_ROOT    = 3'd5;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic                        accept;
  logic                        a_out;
  logic                        b_out;
  logic                        oor;
  logic [edt_pkg::IDX_W-1:0]   idx_b;

  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [2*C-1:0]              ram_wdata;
  logic [2*C-1:0]              ram_rdata;

  logic signed [C-1:0]         ax;
  logic signed [C-1:0]         ay;
  logic signed [C-1:0]         bx;
  logic signed [C-1:0]         by;
  logic signed [C:0]           diff_x;
  logic signed [C:0]           diff_y;
  logic [C:0]                  mag_x;
  logic [C:0]                  mag_y;
  logic [C-1:0]                dx;
  logic [C-1:0]                dy;
  logic [SQ_W-1:0]             sq_x;
  logic [SQ_W-1:0]             sq_y;
  logic [SUM_W-1:0]            sum;

  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [edt_pkg::DIST_W-1:0]  sqrt_root;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign a_out  = (32'(index_a) >= MAX_CITIES);
  assign b_out  = (32'(index_b) >= MAX_CITIES);

  // Coordinates are taken from their low COORD_BITS bits, zero-filled above.
  assign ram_we    = accept && (kind == edt_pkg::KIND_LOAD) && !a_out;
  assign ram_wdata = {C'($unsigned(coord_x)), C'($unsigned(coord_y))};
  assign ram_raddr = (state == S_IDLE) ? AW'(index_a) : AW'(idx_b);

  edt_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_CITIES)
  ) u_coord_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(index_a)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    bx     = $signed(ram_rdata[2*C-1:C]);
    by     = $signed(ram_rdata[C-1:0]);
    diff_x = {ax[C-1], ax} - {bx[C-1], bx};
    diff_y = {ay[C-1], ay} - {by[C-1], by};
    mag_x  = diff_x[C] ? $unsigned(-diff_x) : $unsigned(diff_x);
    mag_y  = diff_y[C] ? $unsigned(-diff_y) : $unsigned(diff_y);
    sum    = SUM_W'(sq_x) + SUM_W'(sq_y);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (kind == edt_pkg::KIND_QUERY)) begin
          state_next = S_FETCH_B;
        end
      end
      S_FETCH_B: state_next = S_DIFF;
      S_DIFF:    state_next = S_SQUARE;
      S_SQUARE:  state_next = S_SUM;
      S_SUM:     state_next = S_ROOT;
      S_ROOT: begin
        if (sqrt_done) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  assign sqrt_start = (state == S_SUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_ROOT) && sqrt_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_b <= index_b;
      oor   <= a_out || b_out;
    end
    if (state == S_FETCH_B) begin
      ax <= $signed(ram_rdata[2*C-1:C]);
      ay <= $signed(ram_rdata[C-1:0]);
    end
    if (state == S_DIFF) begin
      dx <= mag_x[C-1:0];
      dy <= mag_y[C-1:0];
    end
    if (state == S_SQUARE) begin
      sq_x <= dx * dx;
      sq_y <= dy * dy;
    end
    if ((state == S_ROOT) && sqrt_done) begin
      distance <= oor ? '0 : sqrt_root;
    end
  end

  edt_sqrt #(
    .IN_W (SUM_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum),
    .done     (sqrt_done),
    .root_out (sqrt_root)
  );

endmodule
